@@ hdl/ut8_pkg.sv @@
`default_nettype none
package ut8_pkg;

   // Number of result slots between the decoder and the result port.
   localparam int RspDepth = 4;
   localparam int RspPtrW  = $clog2(RspDepth);
   localparam int RspCntW  = $clog2(RspDepth + 1);

   localparam logic [7:0]  ASCII_LIMIT = 8'h80;
   localparam logic [20:0] SUPP_BASE   = 21'h10000;
   localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
   localparam logic [5:0]  LO_SURR_TAG = 6'b110111;

   // Allowed range of the second byte of a sequence.
   typedef enum logic [2:0] {
      CLS_NORMAL = 3'd0,   // 80..BF
      CLS_E0     = 3'd1,   // A0..BF
      CLS_ED     = 3'd2,   // 80..9F
      CLS_F0     = 3'd3,   // 90..BF
      CLS_F4     = 3'd4    // 80..8F
   } second_class_type;

   typedef enum logic {
      ST_VALID = 1'b0,
      ST_ERROR = 1'b1
   } status_type;

   typedef struct packed {
      logic [15:0] code_unit;
      status_type  status;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic [1:0]       pending;
      logic [4:0]       bits;
      second_class_type cls;
   } lead_type;

endpackage
`default_nettype wire

@@ hdl/ut8_in_stage.sv @@
`default_nettype none
module ut8_in_stage (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,
   input  wire logic       take,
   output logic            byte_valid,
   output logic [7:0]      byte_data
);
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;

   assign req_tready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
         byte_in  = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;
endmodule
`default_nettype wire

@@ hdl/ut8_decode.sv @@
`default_nettype none
module ut8_decode (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        fire,
   input  wire logic [7:0]  data_byte,
   output logic [1:0]       res_count,
   output ut8_pkg::rsp_type res0,
   output ut8_pkg::rsp_type res1
);
   import ut8_pkg::*;

   logic [1:0]       pending_ff, pending_in;
   logic [20:0]      acc_ff, acc_in;
   second_class_type cls_ff, cls_in;
   logic             second_ff, second_in;

   lead_type    lead;
   logic        cont_ok;
   logic [20:0] acc_next;
   logic [1:0]  pend_next;
   logic [19:0] supp;

   function automatic lead_type lead_decode(input logic [7:0] b);
      lead_type r;
      r.valid   = 1'b1;
      r.pending = 2'd0;
      r.bits    = 5'd0;
      r.cls     = CLS_NORMAL;
      if (b inside {[8'hC2:8'hDF]}) begin
         r.pending = 2'd1;
         r.bits    = b[4:0];
      end else if (b inside {[8'hE0:8'hEF]}) begin
         r.pending = 2'd2;
         r.bits    = {1'b0, b[3:0]};
         if (b == 8'hE0) r.cls = CLS_E0;
         else if (b == 8'hED) r.cls = CLS_ED;
      end else if (b inside {[8'hF0:8'hF4]}) begin
         r.pending = 2'd3;
         r.bits    = {2'b00, b[2:0]};
         if (b == 8'hF0) r.cls = CLS_F0;
         else if (b == 8'hF4) r.cls = CLS_F4;
      end else begin
         r.valid = 1'b0;
      end
      return r;
   endfunction

   assign lead = lead_decode(data_byte);

   always_comb begin
      cont_ok = data_byte inside {[8'h80:8'hBF]};
      if (second_ff) begin
         case (cls_ff)
            CLS_E0:  cont_ok = data_byte inside {[8'hA0:8'hBF]};
            CLS_ED:  cont_ok = data_byte inside {[8'h80:8'h9F]};
            CLS_F0:  cont_ok = data_byte inside {[8'h90:8'hBF]};
            CLS_F4:  cont_ok = data_byte inside {[8'h80:8'h8F]};
            default: cont_ok = data_byte inside {[8'h80:8'hBF]};
         endcase
      end
   end

   assign acc_next  = {acc_ff[14:0], data_byte[5:0]};
   assign pend_next = pending_ff - 2'd1;
   assign supp      = 20'(acc_next - SUPP_BASE);

   always_comb begin
      pending_in = pending_ff;
      acc_in     = acc_ff;
      cls_in     = cls_ff;
      second_in  = second_ff;
      res_count  = 2'd0;
      res0       = '{code_unit: 16'h0, status: ST_ERROR, last_of_run: 1'b1};
      res1       = '{code_unit: 16'h0, status: ST_VALID, last_of_run: 1'b1};

      if (pending_ff != 2'd0 && cont_ok) begin
         acc_in     = acc_next;
         pending_in = pend_next;
         second_in  = 1'b0;
         if (pend_next == 2'd0) begin
            acc_in = '0;
            cls_in = CLS_NORMAL;
            if (acc_next < SUPP_BASE) begin
               res_count = 2'd1;
               res0 = '{code_unit: acc_next[15:0], status: ST_VALID, last_of_run: 1'b1};
            end else begin
               res_count = 2'd2;
               res0 = '{code_unit: {HI_SURR_TAG, supp[19:10]}, status: ST_VALID,
                        last_of_run: 1'b0};
               res1 = '{code_unit: {LO_SURR_TAG, supp[9:0]}, status: ST_VALID,
                        last_of_run: 1'b1};
            end
         end
      end else begin
         // Idle, or a broken sequence that is dropped: the byte is taken as a lead.
         pending_in = 2'd0;
         acc_in     = '0;
         cls_in     = CLS_NORMAL;
         second_in  = 1'b0;
         if (lead.valid) begin
            pending_in = lead.pending;
            acc_in     = 21'(lead.bits);
            cls_in     = lead.cls;
            second_in  = 1'b1;
         end
         if (pending_ff != 2'd0) begin
            // The error beat comes first; an ASCII byte follows it.
            if (data_byte < ASCII_LIMIT) begin
               res_count = 2'd2;
               res0.last_of_run = 1'b0;
               res1.code_unit   = {8'h00, data_byte};
            end else begin
               res_count = 2'd1;
            end
         end else if (data_byte < ASCII_LIMIT) begin
            res_count = 2'd1;
            res0 = '{code_unit: {8'h00, data_byte}, status: ST_VALID, last_of_run: 1'b1};
         end else if (!lead.valid) begin
            res_count = 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
         acc_ff     <= '0;
         cls_ff     <= CLS_NORMAL;
         second_ff  <= 1'b0;
      end else if (fire) begin
         pending_ff <= pending_in;
         acc_ff     <= acc_in;
         cls_ff     <= cls_in;
         second_ff  <= second_in;
      end
   end
endmodule
`default_nettype wire

@@ hdl/ut8_rsp_queue.sv @@
`default_nettype none
module ut8_rsp_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [1:0]       push_count,
   input  wire ut8_pkg::rsp_type push0,
   input  wire ut8_pkg::rsp_type push1,
   output logic                  has_room,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output ut8_pkg::rsp_type      head
);
   import ut8_pkg::*;

   rsp_type              entry_ff [RspDepth];
   logic [RspPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RspPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RspCntW-1:0]   count_ff, count_in;
   logic                 pop;

   // Room for two beats, so a byte that yields a surrogate pair always fits.
   assign has_room   = count_ff <= RspCntW'(RspDepth - 2);
   assign rsp_tvalid = count_ff != '0;
   assign pop        = rsp_tvalid && rsp_tready;
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RspPtrW'(push_count);
      rd_ptr_in = rd_ptr_ff + RspPtrW'(pop);
      count_in  = count_ff + RspCntW'(push_count) - RspCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_ff + RspPtrW'(1)] <= push1;
      end
   end
endmodule
`default_nettype wire

@@ hdl/utf8_to_utf16_decoder.sv @@
`default_nettype none
// Channel | Direction | tdata                | tuser       | tlast
// req_    | in        | [7:0] data_byte      | -           | -
// rsp_    | out       | [15:0] code_unit     | [0] status  | last_of_run
//
// One byte is taken per cycle while the queue has room for two beats. A byte
// is held in the input register, decoded there and written into a four-beat
// result queue when taken. A byte that yields a surrogate pair, or an error
// plus an ASCII unit, needs two output beats, so the output port sets the
// rate at such bytes. Reset clears the decoder state and empties the queue;
// stalls on rsp_ back up through the queue into the input register.
module utf8_to_utf16_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [15:0] code_unit
   output logic             rsp_tuser,   // [0] status
   output logic             rsp_tlast
);
   import ut8_pkg::*;

   logic       byte_valid;
   logic [7:0] byte_data;
   logic       has_room;
   logic       take;
   logic [1:0] res_count;
   logic [1:0] push_count;
   rsp_type    res0, res1, head;

   assign take       = byte_valid && has_room;
   assign push_count = take ? res_count : 2'd0;

   ut8_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (take),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   ut8_decode u_dec (
      .clock     (clock),
      .reset     (reset),
      .fire      (take),
      .data_byte (byte_data),
      .res_count (res_count),
      .res0      (res0),
      .res1      (res1)
   );

   ut8_rsp_queue u_q (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push0      (res0),
      .push1      (res1),
      .has_room   (has_room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .head       (head)
   );

   assign rsp_tdata = head.code_unit;
   assign rsp_tuser = head.status;
   assign rsp_tlast = head.last_of_run;
endmodule
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import ut8_pkg::*;

   localparam int RANDOM_BYTES    = 1900;
   localparam int PAUSE_SPACING   = 600;
   localparam int HOLD_AFTER      = 400;
   localparam int HOLD_CYCLES     = 300;
   localparam int SETTLE_CYCLES   = 20;
   localparam int WATCHDOG_CYCLES = 5000;

   typedef struct {
      bit         pause;   // wait for every expected unit before going on
      logic [7:0] data;
   } utf8_item_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] data_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;            // [15:0] code_unit
   logic        rsp_tuser;            // [0] status
   logic        rsp_tlast;

   utf8_item_type utf8_q[$];
   rsp_type       units_q[$];

   // Decoder state as the predictor sees it.
   logic [1:0]       pend      = 2'd0;
   logic [20:0]      acc       = 21'd0;
   second_class_type cls       = CLS_NORMAL;
   logic             at_second = 1'b0;

   int  req_beats    = 0;
   int  rsp_beats    = 0;
   int  bytes_issued = 0;
   int  n_queued     = 0;
   int  n_pauses     = 0;
   int  n_err_units  = 0;
   int  n_pairs      = 0;
   int  errors       = 0;
   int  quiet_cycles = 0;
   logic hold_off    = 1'b0;

   utf8_to_utf16_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic second_class_type lead_class(input logic [7:0] lead);
      case (lead)
         8'hE0: return CLS_E0;
         8'hED: return CLS_ED;
         8'hF0: return CLS_F0;
         8'hF4: return CLS_F4;
         default: return CLS_NORMAL;
      endcase
   endfunction

   function automatic void allowed_range(input second_class_type c,
                                         output logic [7:0] lo, output logic [7:0] hi);
      lo = 8'h80;
      hi = 8'hBF;
      case (c)
         CLS_E0: lo = 8'hA0;
         CLS_ED: hi = 8'h9F;
         CLS_F0: lo = 8'h90;
         CLS_F4: hi = 8'h8F;
         default: ;
      endcase
   endfunction

   function automatic void enter_idle();
      pend      = 2'd0;
      acc       = 21'd0;
      cls       = CLS_NORMAL;
      at_second = 1'b0;
   endfunction

   function automatic void push_unit(input logic [15:0] unit, input status_type st,
                                     input logic last);
      units_q.push_back('{code_unit: unit, status: st, last_of_run: last});
   endfunction

   // Loads the decoder state for a multi-byte lead; returns 0 if b is no such lead.
   function automatic bit lead_start(input logic [7:0] b);
      if (b >= 8'hC2 && b <= 8'hDF) begin
         pend = 2'd1;
         acc  = 21'(b & 8'h1F);
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
         pend = 2'd2;
         acc  = 21'(b & 8'h0F);
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
         pend = 2'd3;
         acc  = 21'(b & 8'h07);
      end else begin
         return 1'b0;
      end
      cls       = lead_class(b);
      at_second = 1'b1;
      return 1'b1;
   endfunction

   function automatic void decode_byte(input logic [7:0] b);
      logic [7:0]  lo, hi;
      logic [20:0] cp;
      if (pend != 2'd0) begin
         allowed_range(at_second ? cls : CLS_NORMAL, lo, hi);
         if (b >= lo && b <= hi) begin
            acc       = {acc[14:0], b[5:0]};
            pend      = pend - 2'd1;
            at_second = 1'b0;
            if (pend == 2'd0) begin
               cp = acc;
               enter_idle();
               if (cp < SUPP_BASE) begin
                  push_unit(cp[15:0], ST_VALID, 1'b1);
               end else begin
                  cp = cp - SUPP_BASE;
                  push_unit({HI_SURR_TAG, cp[19:10]}, ST_VALID, 1'b0);
                  push_unit({LO_SURR_TAG, cp[9:0]}, ST_VALID, 1'b1);
                  n_pairs++;
               end
            end
         end else begin
            // The broken sequence is dropped and the byte looked at again as a lead.
            enter_idle();
            if (b < ASCII_LIMIT) begin
               push_unit(16'h0000, ST_ERROR, 1'b0);
               push_unit({8'h00, b}, ST_VALID, 1'b1);
            end else begin
               void'(lead_start(b));
               push_unit(16'h0000, ST_ERROR, 1'b1);
            end
         end
      end else if (b < ASCII_LIMIT) begin
         push_unit({8'h00, b}, ST_VALID, 1'b1);
      end else if (!lead_start(b)) begin
         push_unit(16'h0000, ST_ERROR, 1'b1);
      end
   endfunction

   function automatic void queue_byte(input logic [7:0] b);
      utf8_q.push_back('{pause: 1'b0, data: b});
      n_queued++;
   endfunction

   function automatic void queue_pause();
      utf8_q.push_back('{pause: 1'b1, data: 8'h00});
      n_pauses++;
   endfunction

   // One character, either well formed or cut short by a byte out of range.
   task automatic add_char(input bit broken);
      int         kind, cut;
      logic [7:0] lead, lo, hi, b;
      kind = broken ? $urandom_range(1, 3) : $urandom_range(0, 3);
      case (kind)
         0: lead = 8'($urandom_range(8'h7F, 8'h00));
         1: lead = 8'($urandom_range(8'hDF, 8'hC2));
         2: lead = 8'($urandom_range(8'hEF, 8'hE0));
         default: lead = 8'($urandom_range(8'hF4, 8'hF0));
      endcase
      queue_byte(lead);
      cut = broken ? $urandom_range(1, kind) : kind + 1;
      for (int i = 1; i <= kind; i++) begin
         allowed_range(i == 1 ? lead_class(lead) : CLS_NORMAL, lo, hi);
         if (i == cut) begin
            do b = 8'($urandom); while (b >= lo && b <= hi);
            queue_byte(b);
            break;
         end
         queue_byte(8'($urandom_range(hi, lo)));
      end
   endtask

   // Sender: offers the queued bytes, with random gaps except during the hold-off and calm spells.
   always @(negedge clock) begin
      logic       nv;
      logic [7:0] nd;
      int         gap, calm;
      nv = req_tvalid;
      nd = req_tdata;
      if (!reset) begin
         if (req_tvalid && req_beats == bytes_issued) begin
            nv = 1'b0;
            nd = 8'($urandom);
            if (calm > 0) calm--;
            else if ($urandom_range(0, 199) == 0) calm = 150;
            gap = (hold_off || calm > 0) ? 0 : pick_gap();
         end
         if (!nv) begin
            if (gap > 0) begin
               gap--;
            end else if (utf8_q.size() != 0) begin
               if (utf8_q[0].pause) begin
                  if (units_q.size() == 0) void'(utf8_q.pop_front());
               end else begin
                  nd = utf8_q[0].data;
                  void'(utf8_q.pop_front());
                  nv = 1'b1;
                  bytes_issued++;
               end
            end
         end
      end
      req_tvalid <= nv;
      req_tdata  <= nd;
   end

   // Receiver: random stalls, plus one long hold-off that backs the block up.
   always @(negedge clock) begin
      int stall, calm, hold_cnt;
      bit hold_done;
      if (!reset) begin
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_tready <= 1'b0;
            hold_off   <= (hold_cnt != 0);
         end else if (!hold_done && rsp_beats >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_cnt  = HOLD_CYCLES;
            rsp_tready <= 1'b0;
            hold_off   <= 1'b1;
         end else if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (calm > 0) begin
               calm--;
            end else begin
               if ($urandom_range(0, 199) == 0) calm = 150;
               stall = pick_gap();
            end
         end
      end
   end

   // Checks each result beat against the oldest expected unit, then predicts.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_beats++;
            if (units_q.size() == 0) begin
               $error("unexpected result: code_unit %h status %b last_of_run %b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               errors++;
            end else begin
               want = units_q.pop_front();
               if (want.status == ST_ERROR) n_err_units++;
               if (rsp_tdata !== want.code_unit) begin
                  $error("code_unit: expected %h, got %h", want.code_unit, rsp_tdata);
                  errors++;
               end
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %b, got %b", want.status, rsp_tuser);
                  errors++;
               end
               if (rsp_tlast !== want.last_of_run) begin
                  $error("last_of_run: expected %b, got %b", want.last_of_run, rsp_tlast);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata);
            req_beats++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_CYCLES) begin
         $display("No beat moved for %0d cycles; %0d units still expected.",
                  quiet_cycles, units_q.size());
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [7:0] directed[$];
      int         r, next_pause;
      // ASCII ends, smallest of each length and largest of two and four bytes,
      // each narrowed second byte, bad leads, and broken sequences ending in
      // ASCII, in a non-lead and in a fresh lead.
      directed = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80,
                   8'hED, 8'h9F, 8'hBF, 8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F,
                   8'hBF, 8'hBF, 8'h80, 8'hFF, 8'hC2, 8'h41, 8'hE0, 8'h9F, 8'hC2,
                   8'hE1, 8'h80, 8'h80};
      foreach (directed[i]) queue_byte(directed[i]);
      queue_pause();
      next_pause = n_queued + PAUSE_SPACING;
      while (n_queued < RANDOM_BYTES + directed.size()) begin
         r = $urandom_range(0, 99);
         if (r < 70) add_char(1'b0);
         else if (r < 88) add_char(1'b1);
         else queue_byte(8'($urandom));
         if (n_queued >= next_pause) begin
            queue_pause();
            next_pause = n_queued + PAUSE_SPACING;
         end
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (utf8_q.size() != 0 || req_tvalid || units_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Decoded %0d bytes into %0d UTF-16 beats: %0d error beats, %0d surrogate pairs.",
               req_beats, rsp_beats, n_err_units, n_pairs);
      $display("Random stalls on both sides, one %0d-cycle receiver hold-off, %0d drains.",
               HOLD_CYCLES, n_pauses);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
